// File: design/mi4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi4_pkg: shared constants for the 4x4 matrix inverse unit
// Matrix geometry, minor element lookup and the result tag.
// ----------------------------------------------------------------------------
package mi4_pkg;
   localparam int N_ELEM   = 16;
   localparam int IDX_BITS = 4;

   // Element of a 3x3 minor: storage index of the element used for adjugate
   // entry k, minor row i, minor column j.
   function automatic logic [3:0] minor_index(input logic [3:0] k, input logic [1:0] i,
                                               input logic [1:0] j);
      logic [1:0] r;
      logic [1:0] c;
      logic [1:0] row;
      logic [1:0] col;
      r = k[3:2];
      c = k[1:0];
      row = (i < c) ? i : i + 2'd1;
      col = (j < r) ? j : j + 2'd1;
      return {row, col};
   endfunction

   typedef struct packed {
      logic                last;
      logic [IDX_BITS-1:0] index;
   } tag_type;
endpackage

// File: design/mi4_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi4_ram: generic single-write, single-read RAM
// Registered read port.
// ----------------------------------------------------------------------------
module mi4_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// File: design/mi4_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi4_front: element loader
// Counts elements, writes them into the matrix buffer and hands a complete
// matrix (buffer bank) to the back end.
// ----------------------------------------------------------------------------
module mi4_front (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   output logic       wr_en,
   output logic [4:0] wr_addr,
   output logic       done_valid,
   input  logic       done_ready,
   output logic       done_bank
);
   logic [3:0] cnt_ff, cnt_in;
   logic       bank_ff, bank_in;
   logic       pend_ff, pend_in;
   logic       pbank_ff, pbank_in;
   logic       take;

   // A waiting matrix sits in the bank the back end will read after the
   // current one, so loading stops until the back end takes it.
   assign full = pend_ff;
   assign take = push && !full;
   assign wr_en = take;
   assign wr_addr = {bank_ff, cnt_ff};
   assign done_valid = pend_ff;
   assign done_bank = pbank_ff;

   always_comb begin
      cnt_in = cnt_ff;
      bank_in = bank_ff;
      pend_in = pend_ff && !done_ready;
      pbank_in = pbank_ff;
      if (take) begin
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            bank_in = ~bank_ff;
            pend_in = 1'b1;
            pbank_in = bank_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         bank_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         bank_ff <= bank_in;
         pend_ff <= pend_in;
      end
      pbank_ff <= pbank_in;
   end
endmodule

// File: design/mi4_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi4_back: cofactor, determinant and divide sequencer
// Reads a stored matrix, accumulates each adjugate entry from six triple
// products on one multiplier, forms the determinant, then divides each
// entry bit-serially and pushes results into the output queue.
// ----------------------------------------------------------------------------
module mi4_back #(
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 bank,
   output logic [4:0]           rd_addr,
   input  logic [WORD_BITS-1:0] rd_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [WORD_BITS-1:0] out_value,
   output mi4_pkg::tag_type     out_tag,
   output logic                 out_singular,
   output logic                 out_overflow
);
   localparam int AW = 3 * WORD_BITS + 4;            // adjugate width
   localparam int DW = 4 * WORD_BITS + 4;            // determinant width
   localparam int NW = AW + 2 * FRAC_BITS;           // shifted numerator
   localparam int QB = NW + 1;                       // quotient bits
   localparam int CW = $clog2(QB + 2);
   localparam int MW = 2 * WORD_BITS + 1;            // multiplier product

   localparam logic [2:0] S_IDLE = 3'd0, S_ADJ = 3'd1, S_DET = 3'd2, S_RD = 3'd3,
                          S_DIV = 3'd4, S_OUT = 3'd5;

   logic [2:0]  st_ff, st_in;
   logic [3:0]  k_ff, k_in;
   logic [2:0]  term_ff, term_in;
   logic [2:0]  ph_ff, ph_in;
   logic        bank_ff, bank_in;
   logic [AW-1:0] adj_ff [16];
   logic [AW-1:0] acc_ff, acc_in;
   logic [DW-1:0] det_ff, det_in;
   logic [WORD_BITS-1:0] e0_ff, e1_ff, e2_ff;
   logic [2*WORD_BITS-1:0] p_ff;
   logic [CW-1:0] n_ff, n_in;
   logic [NW-1:0] num_ff, num_in;
   logic [DW:0]   rem_ff, rem_in;
   logic [QB-1:0] q_ff, q_in;
   logic          neg_ff, neg_in;
   logic          sing_ff, sing_in;

   // Adjugate: per term, phases 0-2 read the three elements (the RAM read is
   // registered), phase 3 forms e0*e1, phases 4 and 5 multiply the low and high
   // halves of that product by e2 and accumulate.
   logic [1:0] sub;
   logic [1:0] tj;
   logic       tsign;
   assign sub = ph_ff[1:0];
   assign tsign = (term_ff == 3'd1 || term_ff == 3'd2 || term_ff == 3'd5);

   always_comb begin
      tj = 2'd0;
      unique case (term_ff)
         3'd0: tj = sub;
         3'd1: tj = (sub == 2'd0) ? 2'd0 : (sub == 2'd1) ? 2'd2 : 2'd1;
         3'd2: tj = (sub == 2'd0) ? 2'd1 : (sub == 2'd1) ? 2'd0 : 2'd2;
         3'd3: tj = (sub == 2'd0) ? 2'd1 : (sub == 2'd1) ? 2'd2 : 2'd0;
         3'd4: tj = (sub == 2'd0) ? 2'd2 : (sub == 2'd1) ? 2'd0 : 2'd1;
         default: tj = (sub == 2'd0) ? 2'd2 : (sub == 2'd1) ? 2'd1 : 2'd0;
      endcase
   end

   always_comb begin
      if (st_ff == S_DET) rd_addr = {bank_ff, 2'd0, k_ff[1:0]};
      else rd_addr = {bank_ff, mi4_pkg::minor_index(k_ff, sub, tj)};
   end

   // Determinant: per first-row element, phase 0 reads it, phase 1 latches
   // it, phases 2-5 multiply it by one word-wide slice of adj[4k] each.
   logic [1:0]             chunk;
   logic [4*WORD_BITS-1:0] adj_ext;
   logic [WORD_BITS-1:0]   adj_chunk;
   assign chunk = ph_ff[1:0] - 2'd2;
   assign adj_ext = (4 * WORD_BITS)'($signed(adj_ff[{k_ff[1:0], 2'd0}]));
   assign adj_chunk = adj_ext[WORD_BITS * chunk +: WORD_BITS];

   // One shared (W+1) x W signed multiplier.
   logic signed [WORD_BITS:0]   mul_a;
   logic signed [WORD_BITS-1:0] mul_b;
   logic signed [MW-1:0]        mprod;
   always_comb begin
      mul_a = {1'b0, p_ff[WORD_BITS-1:0]};
      mul_b = e2_ff;
      if (st_ff == S_DET) begin
         mul_a = (chunk == 2'd3) ? {adj_chunk[WORD_BITS-1], adj_chunk} : {1'b0, adj_chunk};
      end else if (ph_ff == 3'd3) begin
         mul_a = {e0_ff[WORD_BITS-1], e0_ff};
         mul_b = e1_ff;
      end else if (ph_ff == 3'd5) begin
         mul_a = {p_ff[2*WORD_BITS-1], p_ff[2*WORD_BITS-1:WORD_BITS]};
      end
   end
   assign mprod = MW'(mul_a) * MW'(mul_b);

   logic [AW-1:0] tv, acc_sum, adj_fin;
   logic [DW-1:0] dv;
   logic          adj_wr;
   assign tv = (ph_ff == 3'd5) ? (AW'(mprod) << WORD_BITS) : AW'(mprod);
   assign acc_sum = tsign ? acc_ff - tv : acc_ff + tv;
   assign adj_fin = (k_ff[2] ^ k_ff[0]) ? AW'(-acc_sum) : acc_sum;
   assign adj_wr = st_ff == S_ADJ && ph_ff == 3'd5 && term_ff == 3'd5;
   assign dv = DW'(mprod) << (WORD_BITS * chunk);

   logic [DW-1:0] den_abs;
   logic [DW:0]   rem_sh, rem_sub;
   logic signed [AW-1:0] adj_sel;
   assign den_abs = det_ff[DW-1] ? DW'(-det_ff) : det_ff;
   assign adj_sel = $signed(adj_ff[k_ff]);

   localparam logic [QB-1:0] LIM = QB'(1) << (WORD_BITS - 1);
   logic [QB-1:0] qr;
   logic          ovf;
   logic [WORD_BITS-1:0] val;
   logic          obuf_ff, oq_full;

   always_comb begin
      rem_sh = {rem_ff[DW-1:0], num_ff[NW-1]};
      rem_sub = rem_sh - {1'b0, den_abs};
   end

   always_comb begin
      qr = q_ff + QB'(!rem_ff[DW]);
      ovf = 1'b0;
      if (neg_ff) begin
         if (qr > LIM) begin
            qr = LIM;
            ovf = 1'b1;
         end
         val = WORD_BITS'(-qr);
      end else begin
         if (qr > LIM - QB'(1)) begin
            qr = LIM - QB'(1);
            ovf = 1'b1;
         end
         val = WORD_BITS'(qr);
      end
      if (sing_ff) begin
         val = '0;
         ovf = 1'b0;
      end
   end

   always_comb begin
      st_in = st_ff;
      k_in = k_ff;
      term_in = term_ff;
      ph_in = ph_ff;
      bank_in = bank_ff;
      acc_in = acc_ff;
      det_in = det_ff;
      n_in = n_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      neg_in = neg_ff;
      sing_in = sing_ff;
      unique case (st_ff)
         S_IDLE: begin
            if (start) begin
               st_in = S_ADJ;
               bank_in = bank;
               k_in = '0;
               term_in = '0;
               ph_in = '0;
               acc_in = '0;
            end
         end
         S_ADJ: begin
            ph_in = ph_ff + 3'd1;
            if (ph_ff == 3'd4 || ph_ff == 3'd5) acc_in = acc_sum;
            if (ph_ff == 3'd5) begin
               ph_in = '0;
               term_in = term_ff + 3'd1;
               if (term_ff == 3'd5) begin
                  term_in = '0;
                  acc_in = '0;
                  k_in = k_ff + 4'd1;
                  if (k_ff == 4'd15) begin
                     st_in = S_DET;
                     det_in = '0;
                  end
               end
            end
         end
         S_DET: begin
            ph_in = ph_ff + 3'd1;
            if (ph_ff >= 3'd2) det_in = det_ff + dv;
            if (ph_ff == 3'd5) begin
               ph_in = '0;
               k_in = k_ff + 4'd1;
               if (k_ff == 4'd3) begin
                  st_in = S_RD;
                  k_in = '0;
               end
            end
         end
         S_RD: begin
            sing_in = ~|det_ff;
            neg_in = adj_sel[AW-1] ^ det_ff[DW-1];
            num_in = NW'(adj_sel[AW-1] ? AW'(-adj_sel) : AW'(adj_sel)) << (2 * FRAC_BITS);
            rem_in = '0;
            q_in = '0;
            n_in = '0;
            st_in = S_DIV;
         end
         S_DIV: begin
            num_in = num_ff << 1;
            n_in = n_ff + CW'(1);
            if (n_ff == CW'(NW)) begin
               st_in = S_OUT;
               rem_in = rem_sub;   // sign bit tells whether 2*rem >= den
            end else if (!rem_sub[DW]) begin
               rem_in = rem_sub;
               q_in = {q_ff[QB-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               q_in = {q_ff[QB-2:0], 1'b0};
            end
         end
         S_OUT: begin
            if (!oq_full) begin
               k_in = k_ff + 4'd1;
               st_in = (k_ff == 4'd15) ? S_IDLE : S_RD;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   // The remainder never exceeds the denominator, so shifting a DW+1 word is exact.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         obuf_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (st_ff == S_OUT && !oq_full) obuf_ff <= 1'b1;
         else if (out_ready) obuf_ff <= 1'b0;
      end
      k_ff <= k_in;
      term_ff <= term_in;
      ph_ff <= ph_in;
      bank_ff <= bank_in;
      acc_ff <= acc_in;
      det_ff <= det_in;
      n_ff <= n_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      q_ff <= q_in;
      neg_ff <= neg_in;
      sing_ff <= sing_in;
      if (st_ff == S_ADJ && ph_ff == 3'd1) e0_ff <= rd_data;
      if (st_ff == S_ADJ && ph_ff == 3'd2) e1_ff <= rd_data;
      if ((st_ff == S_ADJ && ph_ff == 3'd3) || (st_ff == S_DET && ph_ff == 3'd1))
         e2_ff <= rd_data;
      if (st_ff == S_ADJ && ph_ff == 3'd3) p_ff <= mprod[2*WORD_BITS-1:0];
      if (adj_wr) adj_ff[k_ff] <= adj_fin;
      if (st_ff == S_OUT && !oq_full) begin
         out_value <= val;
         out_tag.index <= k_ff;
         out_tag.last <= k_ff == 4'd15;
         out_singular <= sing_ff;
         out_overflow <= ovf;
      end
   end

   assign oq_full = obuf_ff && !out_ready;
   assign out_valid = obuf_ff;
   assign busy = st_ff != S_IDLE;
endmodule

// File: design/matrix_inverse_4x4_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_4x4_unit: streaming 4x4 fixed-point matrix inverse
// Loads sixteen elements, forms the adjugate and determinant, then emits
// the sixteen rounded, saturated inverse elements.
// ----------------------------------------------------------------------------
// channel   ports                     direction
// request   req_push/req_full, req_element_value          in
// response  rsp_pop/rsp_empty, rsp_result_value, rsp_result_index,
//           rsp_is_last, rsp_singular, rsp_overflow        out
//
// Loading takes one element per cycle into a double-buffered matrix RAM; req_full
// is high while a complete matrix waits for the busy back end.
// The back end forms each adjugate entry from six terms on one shared multiplier,
// then the determinant, then divides each result bit-serially.
// Reset is synchronous; a stalled pop holds the result and the back end waits.
// ----------------------------------------------------------------------------
module matrix_inverse_4x4_unit #(
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [WORD_BITS-1:0] req_element_value,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [WORD_BITS-1:0] rsp_result_value,
   output logic [3:0]           rsp_result_index,
   output logic                 rsp_is_last,
   output logic                 rsp_singular,
   output logic                 rsp_overflow
);
   logic       wr_en;
   logic [4:0] wr_addr, rd_addr;
   logic [WORD_BITS-1:0] rd_data;
   logic       done_valid, done_bank, busy, out_valid;
   mi4_pkg::tag_type tag;

   mi4_front u_front (
      .clock(clock), .reset(reset), .push(req_push), .full(req_full),
      .wr_en(wr_en), .wr_addr(wr_addr), .done_valid(done_valid),
      .done_ready(!busy), .done_bank(done_bank)
   );

   mi4_ram #(.WIDTH(WORD_BITS), .DEPTH(32)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(req_element_value),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   mi4_back #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_back (
      .clock(clock), .reset(reset), .start(done_valid), .busy(busy),
      .bank(done_bank), .rd_addr(rd_addr), .rd_data(rd_data),
      .out_valid(out_valid), .out_ready(rsp_pop), .out_value(rsp_result_value),
      .out_tag(tag), .out_singular(rsp_singular), .out_overflow(rsp_overflow)
   );

   assign rsp_empty = !out_valid;
   assign rsp_result_index = tag.index;
   assign rsp_is_last = tag.last;
endmodule

// File: design/mi4_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi4_checker: port-level checks for the matrix inverse unit
// Watches the response channel ordering and flags.
// ----------------------------------------------------------------------------
module mi4_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [3:0] rsp_result_index,
   input logic       rsp_is_last,
   input logic       rsp_singular,
   input logic       rsp_overflow
);
   a_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_is_last == (rsp_result_index == 4'd15)))
      else $error("is_last mismatch");
   a_sing: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_singular |-> !rsp_overflow)
      else $error("singular with overflow");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_result_index))
      else $error("result dropped");
endmodule

bind matrix_inverse_4x4_unit mi4_checker u_mi4_checker (
   .clock(clock), .reset(reset), .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
   .rsp_result_index(rsp_result_index), .rsp_is_last(rsp_is_last),
   .rsp_singular(rsp_singular), .rsp_overflow(rsp_overflow)
);

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for matrix_inverse_4x4_unit
// Streams 4x4 Q16.16 matrices in one element per transaction. Each inverse is
// predicted exactly with wide integers: the cofactor adjugate divided by the
// determinant, rounded and saturated. Response transactions are checked field
// by field against the oldest predicted element.
// ----------------------------------------------------------------------------
module tb;
   localparam int FRAC  = 16;
   localparam int WORD  = 32;
   localparam int LINGER = 400;   // quiet cycles after the last response

   typedef logic signed [191:0] wide_type;

   typedef struct {
      logic [WORD-1:0] value;
      logic [3:0]      index;
      logic            last;
      logic            singular;
      logic            overflow;
   } inv_elem_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_push = 1'b0;
   logic            req_full;
   logic [WORD-1:0] req_element_value = '0;
   logic            rsp_empty;
   logic            rsp_pop = 1'b0;
   logic [WORD-1:0] rsp_result_value;
   logic [3:0]      rsp_result_index;
   logic            rsp_is_last;
   logic            rsp_singular;
   logic            rsp_overflow;

   // Elements waiting to be pushed, and inverse elements not yet popped.
   logic [WORD-1:0] element_fifo[$];
   inv_elem_type    inverse_fifo[$];

   // Predictor state: the matrix under load and the next storage position.
   logic signed [WORD-1:0] shadow_matrix[mi4_pkg::N_ELEM];
   logic [3:0]             shadow_count = '0;

   int mismatches = 0;
   int sent_count = 0;
   int total_items = 0;
   // Idle odds in percent for the request and response sides.
   int push_idle = 10;
   int pop_idle  = 63;

   always #6 clock = ~clock;

   matrix_inverse_4x4_unit #(.FRAC_BITS(FRAC), .WORD_BITS(WORD)) dut (.*);

   // Signed 3x3 minor for adjugate storage position k: drop row (k&3) and
   // column (k>>2) of the stored matrix, i.e. the transposed cofactor.
   function automatic wide_type cofactor_of(input int k);
      int       r;
      int       c;
      int       rows[3];
      int       cols[3];
      int       n;
      wide_type e[3][3];
      wide_type acc;
      r = k >> 2;
      c = k & 3;
      n = 0;
      for (int i = 0; i < 4; i++) if (i != c) begin rows[n] = i; n++; end
      n = 0;
      for (int i = 0; i < 4; i++) if (i != r) begin cols[n] = i; n++; end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            e[i][j] = shadow_matrix[rows[i] * 4 + cols[j]];
      acc = e[0][0] * e[1][1] * e[2][2] - e[0][0] * e[1][2] * e[2][1]
          - e[0][1] * e[1][0] * e[2][2] + e[0][1] * e[1][2] * e[2][0]
          + e[0][2] * e[1][0] * e[2][1] - e[0][2] * e[1][1] * e[2][0];
      if ((r + c) & 1) acc = -acc;
      return acc;
   endfunction

   // adj * 2^(2F) / det, rounded half away from zero, clamped to the word.
   function automatic void quotient_of(input wide_type adj, input wide_type det,
                                       output logic [WORD-1:0] q_out,
                                       output logic ovf);
      wide_type num;
      wide_type un;
      wide_type ud;
      wide_type q;
      wide_type rm;
      logic     neg;
      wide_type lim;
      num = adj <<< (2 * FRAC);
      neg = (num < 0) ^ (det < 0);
      un = (num < 0) ? -num : num;
      ud = (det < 0) ? -det : det;
      q = un / ud;
      rm = un % ud;
      if (rm * 2 >= ud) q = q + 1;
      lim = wide_type'(1) <<< (WORD - 1);
      ovf = 1'b0;
      if (neg) begin
         if (q > lim) begin ovf = 1'b1; q = lim; end
         q = -q;
      end else begin
         if (q > lim - 1) begin ovf = 1'b1; q = lim - 1; end
      end
      q_out = q[WORD-1:0];
   endfunction

   // Store one element; the sixteenth produces the whole inverse.
   task automatic load_element(input logic [WORD-1:0] v);
      wide_type     adj[mi4_pkg::N_ELEM];
      wide_type     det;
      inv_elem_type x;
      shadow_matrix[shadow_count] = v;
      shadow_count = shadow_count + 4'd1;
      if (shadow_count != 0) return;
      for (int k = 0; k < mi4_pkg::N_ELEM; k++) adj[k] = cofactor_of(k);
      det = 0;
      for (int k = 0; k < 4; k++) det = det + adj[k * 4] * wide_type'(shadow_matrix[k]);
      for (int k = 0; k < mi4_pkg::N_ELEM; k++) begin
         x.index = k[3:0];
         x.last = (k == mi4_pkg::N_ELEM - 1);
         x.singular = (det == 0);
         if (det == 0) begin
            x.value = '0;
            x.overflow = 1'b0;
         end else begin
            quotient_of(adj[k], det, x.value, x.overflow);
         end
         inverse_fifo.push_back(x);
      end
   endtask

   task automatic queue_matrix(input logic [WORD-1:0] m[mi4_pkg::N_ELEM]);
      for (int i = 0; i < mi4_pkg::N_ELEM; i++) element_fifo.push_back(m[i]);
   endtask

   // Driver: all inputs change on the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         rsp_pop <= 1'b0;
      end else begin
         if (element_fifo.size() > 0 && $urandom_range(99) >= push_idle) begin
            req_push <= 1'b1;
            req_element_value <= element_fifo[0];
         end else begin
            req_push <= 1'b0;
            req_element_value <= $urandom;
         end
         rsp_pop <= ($urandom_range(99) >= pop_idle);
      end
   end

   // Monitor: request and response transactions sampled on the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) begin
            load_element(element_fifo.pop_front());
            sent_count++;
            // Phase of idling follows progress through the stimulus.
            if (sent_count == total_items / 3) begin
               push_idle = 63;
               pop_idle = 10;
            end else if (sent_count == 2 * total_items / 3) begin
               push_idle = 0;
               pop_idle = 0;
            end
         end
         if (rsp_pop && !rsp_empty) begin
            if (inverse_fifo.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response: value %h index %0d",
                           rsp_result_value, rsp_result_index);
            end else begin
               inv_elem_type x;
               x = inverse_fifo.pop_front();
               if (rsp_result_value !== x.value || rsp_result_index !== x.index ||
                   rsp_is_last !== x.last || rsp_singular !== x.singular ||
                   rsp_overflow !== x.overflow) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp %h/%0d/%b/%b/%b got %h/%0d/%b/%b/%b",
                              x.value, x.index, x.last, x.singular, x.overflow,
                              rsp_result_value, rsp_result_index, rsp_is_last,
                              rsp_singular, rsp_overflow);
               end
            end
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      logic [WORD-1:0] m[mi4_pkg::N_ELEM];
      int              kind;
      // Identity scaled to one LSB: the inverse saturates everywhere on the diagonal.
      for (int i = 0; i < mi4_pkg::N_ELEM; i++) m[i] = (i % 5 == 0) ? 32'd1 : 32'd0;
      queue_matrix(m);
      // All zero: singular.
      for (int i = 0; i < mi4_pkg::N_ELEM; i++) m[i] = '0;
      queue_matrix(m);
      // Word extremes mixed with 1.0 and -1.0.
      m = '{32'h7fffffff, 32'h80000000, 32'h00010000, 32'hffff0000,
            32'h00000000, 32'h7fffffff, 32'h80000000, 32'h00010000,
            32'hffffffff, 32'h00000001, 32'h7fffffff, 32'h80000000,
            32'h00010000, 32'hffff0000, 32'h00000001, 32'h7fffffff};
      queue_matrix(m);
      // Random matrices: about half diagonally dominant, some small, some raw words,
      // some with a duplicated row so they are singular.
      for (int n = 0; n < 20; n++) begin
         kind = $urandom_range(9);
         for (int i = 0; i < mi4_pkg::N_ELEM; i++) begin
            if (kind < 5)
               m[i] = (i % 5 == 0) ? ($urandom_range(1) ? 32'h0 + $urandom_range(20'hfffff, 20'h10000)
                                                        : -($urandom_range(20'hfffff, 20'h10000)))
                                   : $signed($urandom_range(32'h1ffff)) - 32'sh10000;
            else if (kind < 7)
               m[i] = $signed($urandom_range(32'h3ff)) - 32'sh200;
            else
               m[i] = $urandom;
         end
         if (kind == 9)
            for (int j = 0; j < 4; j++) m[4 + j] = m[j];
         queue_matrix(m);
      end
      total_items = element_fifo.size();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (element_fifo.size() != 0 || inverse_fifo.size() != 0) @(posedge clock);
      repeat (LINGER) @(posedge clock);
      if (mismatches == 0 && inverse_fifo.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #60ms;
      $display("Verification failed");
      $finish;
   end
endmodule
